### rtl/core/pts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the path type segmenter.
package pts_pkg;

  localparam int CMD_W       = 3;
  localparam int TYPE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int COUNT_W     = 9;
  localparam int INDEX_W     = 8;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  localparam int MARKER_BIT = 5;
  localparam int CLOSE_BIT  = 7;

  localparam logic [KIND_W-1:0] KIND_START = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LINE  = 3'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_LOAD    = 3'd1,
    CMD_SUBPATH = 3'd2,
    CMD_MARKER  = 3'd3,
    CMD_RUN     = 3'd4,
    CMD_COUNT   = 3'd5,
    CMD_REWIND  = 3'd6
  } cmd_e_t;

  // Result item, last field in the lowest bits.
  typedef struct packed {
    logic               overflow;
    logic               is_closed;
    logic [KIND_W-1:0]  run_kind;
    logic [INDEX_W-1:0] end_index;
    logic [INDEX_W-1:0] start_index;
    logic [COUNT_W-1:0] result_count;
  } res_t;

  typedef struct packed {
    logic   start;
    cmd_e_t cmd;
  } scan_ctl_t;

  typedef struct packed {
    logic              done;
    logic [TYPE_W-1:0] last_byte;
  } scan_sts_t;

endpackage

### rtl/core/pts_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module pts_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/pts_scan.sv
`timescale 1ns / 1ps
// Scan unit: walks the type table one entry per cycle until a boundary or the limit.
module pts_scan import pts_pkg::*; #(
  parameter int MAX_POINTS = 256,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scan_ctl_t         ctl,
  input  logic [CW-1:0]     first_idx,
  input  logic [CW-1:0]     limit,
  input  logic [TYPE_W-1:0] rd_data,
  output logic [AW-1:0]     rd_addr,
  output scan_sts_t         sts,
  output logic [CW-1:0]     end_idx,
  output logic [CW-1:0]     acc
);

  logic              busy_r, busy_nxt;
  logic              first_r, first_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     limit_r, limit_nxt;
  logic [CW-1:0]     acc_r, acc_nxt;
  logic [TYPE_W-1:0] byte_r, byte_nxt;
  cmd_e_t            cmd_r, cmd_nxt;
  logic [CW-1:0]     i_plus1;
  logic [KIND_W-1:0] kind;
  logic              stop;
  logic              adv;
  logic [CW-1:0]     end_sel;

  assign i_plus1 = i_r + CW'(1);
  assign kind    = rd_data[KIND_W-1:0];

  always_comb begin
    busy_nxt  = busy_r;
    first_nxt = first_r;
    i_nxt     = i_r;
    limit_nxt = limit_r;
    acc_nxt   = acc_r;
    byte_nxt  = byte_r;
    cmd_nxt   = cmd_r;
    stop      = 1'b0;
    adv       = 1'b0;
    end_sel   = i_r;
    if (ctl.start) begin
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
      i_nxt     = first_idx;
      limit_nxt = limit;
      acc_nxt   = '0;
      cmd_nxt   = ctl.cmd;
    end else if (busy_r) begin
      // rd_data holds the entry at i_r
      if (i_r >= limit_r) begin
        stop = 1'b1;
      end else begin
        case (cmd_r)
          CMD_SUBPATH: begin
            if (!first_r && kind == KIND_START) stop = 1'b1;
            else adv = 1'b1;
          end
          CMD_MARKER: begin
            if (rd_data[MARKER_BIT]) begin
              stop    = 1'b1;
              end_sel = i_plus1;
            end else begin
              adv = 1'b1;
            end
          end
          CMD_RUN: begin
            if (!first_r && kind != byte_r[KIND_W-1:0]) stop = 1'b1;
            else adv = 1'b1;
          end
          CMD_COUNT: begin
            adv = 1'b1;
            if (kind == KIND_START) acc_nxt = acc_r + CW'(1);
          end
          default: begin
            stop = 1'b1;
          end
        endcase
      end
      if (adv) begin
        i_nxt     = i_plus1;
        first_nxt = 1'b0;
        byte_nxt  = rd_data;
      end
      if (stop) busy_nxt = 1'b0;
    end
  end

  // Prefetch the next entry so one entry is checked per cycle.
  assign rd_addr = ctl.start ? first_idx[AW-1:0] : i_plus1[AW-1:0];

  assign sts.done      = stop;
  assign sts.last_byte = byte_r;
  assign end_idx       = end_sel;
  assign acc           = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    i_r     <= i_nxt;
    limit_r <= limit_nxt;
    acc_r   <= acc_nxt;
    byte_r  <= byte_nxt;
    cmd_r   <= cmd_nxt;
  end

endmodule

### rtl/core/path_type_segmenter.sv
`timescale 1ns / 1ps
// Top level: command sequencer, cursors, type table and result register.
//
//  channel | dir | ports                      | item
//  --------+-----+----------------------------+----------------------------------
//  in      | in  | in_tvalid/tready/tdata     | command, type_byte
//  out     | out | out_tvalid/tready/tdata    | count, start, end, kind, closed, ovf
//
// Clear, load, rewind and early-out queries go from idle straight to the done
// state, which registers the result onto out_tdata. Scanning queries pass
// through the scan state first, one table entry per cycle through the single
// RAM read port. in_tready is low while a command is in progress; a result
// waiting on out_tready holds the next command only in its done state.
// Reset (rst_n low, synchronous) empties the table and zeroes all cursors.
module path_type_segmenter import pts_pkg::*; #(
  parameter int MAX_POINTS = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] command, [10:3] type_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [8:0] result_count, [16:9] start_index,
                                             // [24:17] end_index, [27:25] run_kind,
                                             // [28] is_closed, [29] overflow
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int WW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     pt_r, pt_nxt;
  logic [CW-1:0]     mc_r, mc_nxt;
  logic [CW-1:0]     sc_r, sc_nxt;
  logic [CW-1:0]     rc_r, rc_nxt;
  logic [CW-1:0]     base_r, base_nxt;
  cmd_e_t            cmd_r, cmd_nxt;
  res_t              res_r, res_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic              in_fire;
  cmd_e_t            in_cmd;
  logic [TYPE_W-1:0] in_type;

  scan_ctl_t         scan_ctl;
  scan_sts_t         scan_sts;
  logic [CW-1:0]     scan_first;
  logic [CW-1:0]     scan_limit;
  logic [CW-1:0]     scan_end;
  logic [CW-1:0]     scan_acc;

  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [TYPE_W-1:0] ram_rdata;

  logic [CW-1:0]     run_len;
  logic [CW-1:0]     last_idx;
  logic [WW-1:0]     cnt_w;
  logic [WW-1:0]     st_w;
  logic [WW-1:0]     en_w;
  logic [WW-1:0]     acc_w;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_cmd    = cmd_e_t'(in_tdata[CMD_W-1:0]);
  assign in_type   = in_tdata[CMD_W +: TYPE_W];

  assign run_len  = scan_end - base_r;
  assign last_idx = scan_end - CW'(1);
  assign cnt_w    = WW'(run_len);
  assign st_w     = WW'(base_r);
  assign en_w     = WW'(last_idx);
  assign acc_w    = WW'(scan_acc);

  always_comb begin
    state_nxt      = state_r;
    pt_nxt         = pt_r;
    mc_nxt         = mc_r;
    sc_nxt         = sc_r;
    rc_nxt         = rc_r;
    base_nxt       = base_r;
    cmd_nxt        = cmd_r;
    res_nxt        = res_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    ram_we         = 1'b0;
    scan_ctl.start = 1'b0;
    scan_ctl.cmd   = in_cmd;
    scan_first     = '0;
    scan_limit     = pt_r;

    if (out_tvalid_r && out_tready) out_tvalid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt   = in_cmd;
          res_nxt   = '0;
          state_nxt = ST_DONE;
          case (in_cmd)
            CMD_CLEAR: begin
              pt_nxt = '0;
              mc_nxt = '0;
              sc_nxt = '0;
              rc_nxt = '0;
            end
            CMD_LOAD: begin
              if (pt_r < MAX_CNT) begin
                ram_we = 1'b1;
                pt_nxt = pt_r + CW'(1);
              end else begin
                res_nxt.overflow = 1'b1;
              end
            end
            CMD_SUBPATH: begin
              if (pt_r == '0) begin
                // empty table: all zero
              end else if (sc_r >= pt_r) begin
                res_nxt.is_closed = 1'b1;
              end else begin
                scan_ctl.start = 1'b1;
                scan_first     = sc_r;
                base_nxt       = sc_r;
                state_nxt      = ST_SCAN;
              end
            end
            CMD_MARKER: begin
              if (mc_r < pt_r) begin
                scan_ctl.start = 1'b1;
                scan_first     = mc_r;
                base_nxt       = mc_r;
                state_nxt      = ST_SCAN;
              end
            end
            CMD_RUN: begin
              if (pt_r != '0 && sc_r != '0 && rc_r < sc_r) begin
                scan_ctl.start = 1'b1;
                // one-point subpath: read that point itself
                scan_first     = ((sc_r - rc_r) == CW'(1)) ? rc_r : rc_r + CW'(1);
                scan_limit     = sc_r;
                base_nxt       = rc_r;
                state_nxt      = ST_SCAN;
              end
            end
            CMD_COUNT: begin
              scan_ctl.start = 1'b1;
              scan_first     = '0;
              state_nxt      = ST_SCAN;
            end
            CMD_REWIND: begin
              mc_nxt = '0;
              sc_nxt = '0;
              rc_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_sts.done) begin
          state_nxt = ST_DONE;
          res_nxt   = '0;
          case (cmd_r)
            CMD_SUBPATH: begin
              res_nxt.result_count = cnt_w[COUNT_W-1:0];
              res_nxt.start_index  = st_w[INDEX_W-1:0];
              res_nxt.end_index    = en_w[INDEX_W-1:0];
              res_nxt.is_closed    = scan_sts.last_byte[CLOSE_BIT];
              rc_nxt               = base_r;
              sc_nxt               = scan_end;
            end
            CMD_MARKER: begin
              res_nxt.result_count = cnt_w[COUNT_W-1:0];
              res_nxt.start_index  = st_w[INDEX_W-1:0];
              res_nxt.end_index    = en_w[INDEX_W-1:0];
              mc_nxt               = scan_end;
            end
            CMD_RUN: begin
              res_nxt.result_count = cnt_w[COUNT_W-1:0];
              res_nxt.start_index  = st_w[INDEX_W-1:0];
              res_nxt.end_index    = en_w[INDEX_W-1:0];
              res_nxt.run_kind     = scan_sts.last_byte[KIND_W-1:0];
              // a line run shares its last point with the next run
              if (scan_sts.last_byte[KIND_W-1:0] == KIND_LINE && scan_end != sc_r) begin
                rc_nxt = last_idx;
              end else begin
                rc_nxt = scan_end;
              end
            end
            CMD_COUNT: begin
              res_nxt.result_count = acc_w[COUNT_W-1:0];
            end
            default: begin
            end
          endcase
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W'(res_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  pts_ram #(
    .DATA_W (TYPE_W),
    .DEPTH  (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pt_r[AW-1:0]),
    .wdata (in_type),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pts_scan #(
    .MAX_POINTS (MAX_POINTS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .first_idx (scan_first),
    .limit     (scan_limit),
    .rd_data   (ram_rdata),
    .rd_addr   (ram_raddr),
    .sts       (scan_sts),
    .end_idx   (scan_end),
    .acc       (scan_acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pt_r         <= '0;
      mc_r         <= '0;
      sc_r         <= '0;
      rc_r         <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pt_r         <= pt_nxt;
      mc_r         <= mc_nxt;
      sc_r         <= sc_nxt;
      rc_r         <= rc_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r      <= base_nxt;
    cmd_r       <= cmd_nxt;
    res_r       <= res_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
